/* sv/bpdc_pkg.sv */
// package for the button press duration classifier
// types, codes and widths shared by the interfaces and all modules; no dependencies
package bpdc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam int ADDR_W      = 3;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HELD = 3'd1,
        PH_FAST = 3'd2,
        PH_SLOW = 3'd3,
        PH_LONG = 3'd4,
        PH_KEEP = 3'd5,
        PH_DONE = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        MD_TICK  = 2'd0,
        MD_ACK   = 2'd1,
        MD_CLEAR = 2'd2,
        MD_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        NT_NONE = 2'd0,
        NT_MARK = 2'd1,
        NT_KEEP = 2'd2
    } t_notify;

    typedef enum logic [2:0] {
        FC_NONE = 3'd0,
        FC_FAST = 3'd1,
        FC_SLOW = 3'd2,
        FC_LONG = 3'd3,
        FC_KEEP = 3'd4
    } t_fired;

    typedef enum logic [ADDR_W-1:0] {
        RG_DEBOUNCE = 3'd0,
        RG_FAST     = 3'd1,
        RG_SLOW     = 3'd2,
        RG_LONG     = 3'd3,
        RG_KEEP     = 3'd4,
        RG_LEVEL    = 3'd5
    } t_reg_addr;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] FAST_RST     = 16'd1;
    localparam logic [CFG_W-1:0] SLOW_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd3000;
    localparam logic [CFG_W-1:0] KEEP_RST     = 16'd5000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] fast_mark;
        logic [CFG_W-1:0] slow_threshold;
        logic [CFG_W-1:0] long_threshold;
        logic [CFG_W-1:0] keep_threshold;
        logic             press_level;
    } t_cfg;

endpackage

/* sv/bpdc_if.sv */
// channel interfaces: input items, result items and register writes
// depends on bpdc_pkg
interface bpdc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       pin_level;
    modport source (output valid, mode, pin_level, input ready);
    modport sink   (input valid, mode, pin_level, output ready);
endinterface

interface bpdc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic [1:0] notify_level;
    logic [2:0] fired_class;
    modport source (output valid, phase, notify_level, fired_class, input ready);
    modport sink   (input valid, phase, notify_level, fired_class, output ready);
endinterface

interface bpdc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bpdc_pkg::ADDR_W-1:0] addr;
    logic [bpdc_pkg::CFG_W-1:0]  data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

/* sv/button_press_duration_classifier.sv */
// top level of the button press duration classifier
// depends on bpdc_pkg, bpdc_if, bpdc_cfg and bpdc_core
//
// One input transaction per 1 ms tick: mode 0 carries the sampled pin, mode 1
// acknowledges the pending class (reported in fired_class) and mode 2 clears
// the sticky notify level. Every input transaction yields exactly one result
// transaction with the phase and notify level after the update. The block
// takes one transaction per clock while the result sink is ready: an input
// register feeds a single layer of counter and threshold compare logic whose
// result lands in an output register, so the rate is set only by the sink's
// ready. Registers are written through the config channel, which is always
// ready; write them only while no transaction is in flight.
// Up and down buttons use separate instances of this block.
module button_press_duration_classifier (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpdc_cfg_if.sink  i_cfg,
    bpdc_in_if.sink   i_in,
    bpdc_out_if.source o_out
);
    import bpdc_pkg::*;

    // input register stage
    logic       r_in_valid;
    logic [1:0] r_in_mode;
    logic       r_in_pin;
    logic       take;
    t_cfg       cfg;

    // free slot when empty or when the core takes the held transaction
    assign i_in.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_mode <= i_in.mode;
            r_in_pin  <= i_in.pin_level;
        end
    end

    // register bank
    bpdc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // state update and result register
    bpdc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (r_in_valid),
        .i_item_mode  (r_in_mode),
        .i_item_pin   (r_in_pin),
        .o_take       (take),
        .o_out        (o_out)
    );

endmodule

/* sv/bpdc_cfg.sv */
// configuration register bank
// depends on bpdc_pkg and bpdc_cfg_if
module bpdc_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bpdc_cfg_if.sink       i_cfg,
    output bpdc_pkg::t_cfg o_cfg
);
    import bpdc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                RG_DEBOUNCE: n_cfg.debounce_ticks = i_cfg.data;
                RG_FAST:     n_cfg.fast_mark      = i_cfg.data;
                RG_SLOW:     n_cfg.slow_threshold = i_cfg.data;
                RG_LONG:     n_cfg.long_threshold = i_cfg.data;
                RG_KEEP:     n_cfg.keep_threshold = i_cfg.data;
                RG_LEVEL:    n_cfg.press_level    = i_cfg.data[0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.fast_mark      <= FAST_RST;
            r_cfg.slow_threshold <= SLOW_RST;
            r_cfg.long_threshold <= LONG_RST;
            r_cfg.keep_threshold <= KEEP_RST;
            r_cfg.press_level    <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* sv/bpdc_core.sv */
// press state update and result register
// depends on bpdc_pkg and bpdc_out_if
module bpdc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpdc_pkg::t_cfg i_cfg,
    input  logic           i_item_valid,
    input  logic [1:0]     i_item_mode,
    input  logic           i_item_pin,
    output logic           o_take,
    bpdc_out_if.source     o_out
);
    import bpdc_pkg::*;

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    t_notify                r_notify;
    t_notify                n_notify;
    t_fired                 n_fired;

    logic                   r_out_valid;
    t_phase                 r_out_phase;
    t_notify                r_out_notify;
    t_fired                 r_out_fired;

    logic                   advance;
    logic                   consume;
    logic                   pressed;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       cnt_inc_x;
    logic [CMP_W-1:0]       deb_x;
    logic [CMP_W-1:0]       fast_x;
    logic [CMP_W-1:0]       slow_x;
    logic [CMP_W-1:0]       long_x;
    logic [CMP_W-1:0]       keep_x;

    assign advance = !r_out_valid || o_out.ready;
    assign consume = i_item_valid && advance;
    assign o_take  = advance;

    assign pressed   = (i_item_pin == i_cfg.press_level);
    // saturating increment, no wrap at the top
    assign count_inc = (&r_count) ? r_count : r_count + 1'b1;
    assign cnt_inc_x = CMP_W'(count_inc);
    assign deb_x     = CMP_W'(i_cfg.debounce_ticks);
    assign fast_x    = CMP_W'(i_cfg.fast_mark);
    assign slow_x    = CMP_W'(i_cfg.slow_threshold);
    assign long_x    = CMP_W'(i_cfg.long_threshold);
    assign keep_x    = CMP_W'(i_cfg.keep_threshold);

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_notify = r_notify;
        n_fired  = FC_NONE;
        unique case (t_mode'(i_item_mode))
            MD_TICK: begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (pressed) begin
                            n_count = count_inc;
                            if (cnt_inc_x >= deb_x) begin
                                n_count = '0;
                                n_phase = PH_HELD;
                            end
                        end
                    end
                    PH_HELD: begin
                        n_count = count_inc;
                        if (!pressed) begin
                            // later matches win, misordered thresholds may leave it held
                            if (cnt_inc_x < slow_x && cnt_inc_x != '0) n_phase = PH_FAST;
                            if (cnt_inc_x >= slow_x && cnt_inc_x < long_x) n_phase = PH_SLOW;
                            if (cnt_inc_x >= long_x && cnt_inc_x < keep_x) n_phase = PH_LONG;
                        end
                        if (cnt_inc_x >= keep_x) n_phase = PH_KEEP;
                        if (cnt_inc_x == fast_x || cnt_inc_x == slow_x || cnt_inc_x == long_x)
                            n_notify = NT_MARK;
                        else if (cnt_inc_x == keep_x)
                            n_notify = NT_KEEP;
                    end
                    PH_DONE: begin
                        if (!pressed) begin
                            n_count = '0;
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            MD_ACK: begin
                if (r_phase == PH_FAST || r_phase == PH_SLOW ||
                    r_phase == PH_LONG || r_phase == PH_KEEP) begin
                    n_fired = t_fired'(r_phase - 3'd1);
                    n_phase = PH_DONE;
                end
            end
            MD_CLEAR: n_notify = NT_NONE;
            default:  n_phase  = r_phase;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_notify    <= NT_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (consume) begin
                r_phase  <= n_phase;
                r_count  <= n_count;
                r_notify <= n_notify;
            end
            if (advance) begin
                r_out_valid <= i_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_out_phase  <= n_phase;
            r_out_notify <= n_notify;
            r_out_fired  <= n_fired;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.phase        = r_out_phase;
    assign o_out.notify_level = r_out_notify;
    assign o_out.fired_class  = r_out_fired;

    a_fired_only_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fired != FC_NONE) |-> r_out_phase == PH_DONE)
        else $error("class fired without moving to handled");

    a_stall_freezes_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_phase == $past(r_phase) &&
                                           r_count == $past(r_count)))
        else $error("press state moved while result stalled");

    a_held_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_phase == PH_HELD && $past(r_phase) != PH_HELD)
            |-> $past(r_phase) == PH_IDLE)
        else $error("held entered from a phase other than idle");

    a_notify_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_notify != 2'd3)
        else $error("notify level out of range");

endmodule

/* sim/tb_button_press_duration_classifier.sv */
`timescale 1ns / 100ps
// self-checking testbench for button_press_duration_classifier
// depends on bpdc_pkg, bpdc_if and the block's rtl; drives a directed table, a top-of-range run, then random presses
module tb_button_press_duration_classifier;
    import bpdc_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 4;     // extra wait after the last result, keep some margin
    localparam int PHASE_ITEMS  = 100;
    localparam int RANDOM_PHASES = 6;
    localparam int DIRECTED_ROWS = 36;
    localparam int TOP_TICKS    = 40;
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;
    localparam logic [CFG_W-1:0] CFG_TOP = '1;

    // one result transaction as the predictor sees it
    typedef struct packed {
        t_phase  phase;
        t_notify notify;
        t_fired  fired;
    } press_result_t;

    // directed table: either an input transaction or a register write
    typedef enum logic {
        RK_ITEM = 1'b0,
        RK_CFG  = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        t_mode             md;
        logic              pin;
        t_reg_addr         reg_addr;
        logic [CFG_W-1:0]  value;
        bit                typed;    // expectation written in the row itself
        press_result_t     want;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpdc_in_if  in_ch ();
    bpdc_out_if out_ch ();
    bpdc_cfg_if cfg_ch ();

    button_press_duration_classifier u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the block: register copy plus button state
    t_cfg                   cfg_shadow;
    t_phase                 st_phase;
    logic [COUNT_WIDTH-1:0] st_count;
    t_notify                st_notify;

    press_result_t expected_results[$];
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            cycle_count = 0;
    int            send_calm = 0;
    bit            steady_run = 1'b0;    // both sides run without idling
    dir_row_t      directed [DIRECTED_ROWS];

    // apply one input transaction to the shadow state and return the result it yields
    function automatic press_result_t advance_button(input t_mode md, input logic pin);
        press_result_t res;
        logic          pressed;
        t_fired        fc;
        pressed = (pin == cfg_shadow.press_level);
        fc = FC_NONE;
        case (md)
            MD_TICK: begin
                case (st_phase)
                    PH_IDLE: begin
                        // debounce: bounces do not clear the count
                        if (pressed) begin
                            if (st_count != COUNT_TOP) st_count = st_count + 1'b1;
                            if (st_count >= cfg_shadow.debounce_ticks) begin
                                st_count = '0;
                                st_phase = PH_HELD;
                            end
                        end
                    end
                    PH_HELD: begin
                        if (st_count != COUNT_TOP) st_count = st_count + 1'b1;
                        // later matches win, misordered thresholds may leave it held
                        if (!pressed) begin
                            if (st_count < cfg_shadow.slow_threshold && st_count != '0)
                                st_phase = PH_FAST;
                            if (st_count >= cfg_shadow.slow_threshold &&
                                st_count < cfg_shadow.long_threshold)
                                st_phase = PH_SLOW;
                            if (st_count >= cfg_shadow.long_threshold &&
                                st_count < cfg_shadow.keep_threshold)
                                st_phase = PH_LONG;
                        end
                        if (st_count >= cfg_shadow.keep_threshold) st_phase = PH_KEEP;
                        if (st_count == cfg_shadow.fast_mark ||
                            st_count == cfg_shadow.slow_threshold ||
                            st_count == cfg_shadow.long_threshold)
                            st_notify = NT_MARK;
                        else if (st_count == cfg_shadow.keep_threshold)
                            st_notify = NT_KEEP;
                    end
                    PH_DONE: begin
                        if (!pressed) begin
                            st_count = '0;
                            st_phase = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            MD_ACK: begin
                case (st_phase)
                    PH_FAST: fc = FC_FAST;
                    PH_SLOW: fc = FC_SLOW;
                    PH_LONG: fc = FC_LONG;
                    PH_KEEP: fc = FC_KEEP;
                    default: fc = FC_NONE;
                endcase
                if (fc != FC_NONE) st_phase = PH_DONE;
            end
            MD_CLEAR: st_notify = NT_NONE;
            default: ;
        endcase
        res.phase  = st_phase;
        res.notify = st_notify;
        res.fired  = fc;
        return res;
    endfunction

    function automatic void note_problem(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    // random pin level
    function automatic logic rand_pin();
        return 1'($urandom_range(0, 1));
    endfunction

    // random register value in a small range
    function automatic logic [CFG_W-1:0] rand_cfg(input int lo, input int hi);
        return CFG_W'($urandom_range(lo, hi));
    endfunction

    // sender gaps: mostly none or short, a few long, with calm stretches
    function automatic int pick_gap();
        int r;
        if (steady_run) return 0;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r < 2) begin
            send_calm = $urandom_range(30, 80);
            return 0;
        end
        if (r < 110) return 0;
        if (r < 180) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one input transaction; returns at the falling edge after acceptance with valid still high
    task automatic send_item(input t_mode md, input logic pin, input bit typed,
                             input press_result_t typed_res);
        int            gap;
        press_result_t res;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= md;
        in_ch.pin_level <= pin;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        res = advance_button(md, pin);
        expected_results.push_back(typed ? typed_res : res);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send(input t_mode md, input logic pin);
        send_item(md, pin, 1'b0, '0);
    endtask

    // stop sending, let every pending result come back, then cover the pipeline
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // register write; returns at the falling edge after acceptance with valid still high
    task automatic write_register(input t_reg_addr ra, input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= ra;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (ra)
            RG_DEBOUNCE: cfg_shadow.debounce_ticks = value;
            RG_FAST:     cfg_shadow.fast_mark      = value;
            RG_SLOW:     cfg_shadow.slow_threshold = value;
            RG_LONG:     cfg_shadow.long_threshold = value;
            RG_KEEP:     cfg_shadow.keep_threshold = value;
            RG_LEVEL:    cfg_shadow.press_level    = value[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] fm,
                                 input logic [CFG_W-1:0] sl, input logic [CFG_W-1:0] lg,
                                 input logic [CFG_W-1:0] kp, input logic lvl);
        settle();
        write_register(RG_DEBOUNCE, deb);
        write_register(RG_FAST, fm);
        write_register(RG_SLOW, sl);
        write_register(RG_LONG, lg);
        write_register(RG_KEEP, kp);
        write_register(RG_LEVEL, {{(CFG_W-1){1'b0}}, lvl});
        cfg_ch.valid <= 1'b0;
    endtask

    // a well-formed press with random content: debounce with bounces, hold, release,
    // acknowledge and let go, with some noise mixed into the hold
    task automatic press_episode();
        int   guard;
        int   hold_len;
        int   hold_cap;
        int   k;
        int   r;
        logic down;
        logic up;
        down = cfg_shadow.press_level;
        up   = ~down;
        guard = 0;
        while (st_phase == PH_IDLE && guard < 200) begin
            if ($urandom_range(0, 4) == 0) send(MD_TICK, up);
            else send(MD_TICK, down);
            guard++;
        end
        hold_cap = (cfg_shadow.keep_threshold > 38) ? 40 : cfg_shadow.keep_threshold + 2;
        hold_len = $urandom_range(0, hold_cap);
        k = 0;
        while (st_phase == PH_HELD && k < hold_len) begin
            r = $urandom_range(0, 19);
            if (r == 0) send(MD_CLEAR, rand_pin());
            else if (r == 1) send(MD_ACK, rand_pin());
            else if (r == 2) send(MD_NONE, rand_pin());
            else send(MD_TICK, down);
            k++;
        end
        if (st_phase == PH_HELD) send(MD_TICK, up);
        // ticks while a class is pending change nothing
        repeat ($urandom_range(0, 2)) send(MD_TICK, rand_pin());
        if ($urandom_range(0, 3) == 0) send(MD_CLEAR, rand_pin());
        if ($urandom_range(0, 9) != 0) send(MD_ACK, rand_pin());
        repeat ($urandom_range(0, 2)) send(MD_TICK, down);
        send(MD_TICK, up);
    endtask

    // output side: random backpressure, mostly short stalls, a few long, calm stretches
    initial begin
        int hold;
        int calm;
        int r;
        out_ch.ready = 1'b0;
        hold = 0;
        calm = 0;
        forever begin
            @(negedge i_clk);
            if (steady_run || calm > 0) begin
                out_ch.ready <= 1'b1;
                if (calm > 0) calm--;
            end else if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 20) hold = $urandom_range(1, 3);
                else if (r < 23) hold = $urandom_range(8, 40);
                else if (r < 25) calm = $urandom_range(40, 120);
            end
        end
    end

    // result checker: every result transaction against the oldest expectation
    always @(posedge i_clk) begin
        press_result_t want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                note_problem($sformatf("unexpected result: phase %0d notify %0d fired %0d",
                                       out_ch.phase, out_ch.notify_level,
                                       out_ch.fired_class));
            end else begin
                want = expected_results.pop_front();
                if (out_ch.phase !== want.phase || out_ch.notify_level !== want.notify ||
                    out_ch.fired_class !== want.fired) begin
                    note_problem($sformatf(
                        "mismatch: phase %0d/%0d notify %0d/%0d fired %0d/%0d (exp/got)",
                        want.phase, out_ch.phase, want.notify, out_ch.notify_level,
                        want.fired, out_ch.fired_class));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int               phase_end;
        int               r;
        logic [CFG_W-1:0] sl;
        logic [CFG_W-1:0] lg;
        logic [CFG_W-1:0] kp;

        // every block input known from time zero
        in_ch.valid     = 1'b0;
        in_ch.mode      = MD_TICK;
        in_ch.pin_level = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.addr     = RG_DEBOUNCE;
        cfg_ch.data     = '0;

        cfg_shadow = '{DEBOUNCE_RST, FAST_RST, SLOW_RST, LONG_RST, KEEP_RST, 1'b0};
        st_phase   = PH_IDLE;
        st_count   = '0;
        st_notify  = NT_NONE;

        // directed table; with the reset settings the pin is pressed when low,
        // afterwards debounce is zero and the thresholds sit at 1, 2, 3 and 4
        directed = '{
            '{RK_ITEM, MD_ACK,   1'b0, RG_DEBOUNCE, 16'd0, 1'b1, '{PH_IDLE, NT_NONE, FC_NONE}},
            '{RK_ITEM, MD_NONE,  1'b1, RG_DEBOUNCE, 16'd0, 1'b1, '{PH_IDLE, NT_NONE, FC_NONE}},
            '{RK_ITEM, MD_CLEAR, 1'b0, RG_DEBOUNCE, 16'd0, 1'b1, '{PH_IDLE, NT_NONE, FC_NONE}},
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b1, '{PH_IDLE, NT_NONE, FC_NONE}},
            '{RK_ITEM, MD_TICK,  1'b0, RG_DEBOUNCE, 16'd0, 1'b1, '{PH_IDLE, NT_NONE, FC_NONE}},
            '{RK_CFG,  MD_TICK,  1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_CFG,  MD_TICK,  1'b0, RG_FAST,     16'd1, 1'b0, '0},
            '{RK_CFG,  MD_TICK,  1'b0, RG_SLOW,     16'd2, 1'b0, '0},
            '{RK_CFG,  MD_TICK,  1'b0, RG_LONG,     16'd3, 1'b0, '0},
            '{RK_CFG,  MD_TICK,  1'b0, RG_KEEP,     16'd4, 1'b0, '0},
            '{RK_CFG,  MD_TICK,  1'b0, RG_LEVEL,    16'd1, 1'b0, '0},
            // zero debounce: first press accepted at once
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_ACK,   1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            // fast press, then clear the notify while handled
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_ACK,   1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_CLEAR, 1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            // long press
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_ACK,   1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            // keep while still held, notify goes to the keep level
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b1, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_TICK,  1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            '{RK_ITEM, MD_ACK,   1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0},
            // second acknowledge finds nothing pending
            '{RK_ITEM, MD_ACK,   1'b1, RG_DEBOUNCE, 16'd0, 1'b1, '{PH_DONE, NT_KEEP, FC_NONE}},
            '{RK_ITEM, MD_TICK,  1'b0, RG_DEBOUNCE, 16'd0, 1'b0, '0}
        };

        // synchronous reset, released once
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part: register writes only once the block has gone quiet
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed[i].kind == RK_CFG) begin
                if (i == 0 || directed[i-1].kind != RK_CFG) settle();
                write_register(directed[i].reg_addr, directed[i].value);
            end else begin
                if (i > 0 && directed[i-1].kind == RK_CFG) cfg_ch.valid <= 1'b0;
                send_item(directed[i].md, directed[i].pin, directed[i].typed,
                          directed[i].want);
            end
        end

        // top of the range: every threshold register at its top value, a debounce that does not
        // finish, then a short press against top thresholds, no idling on either side
        load_settings(CFG_TOP, CFG_TOP, CFG_TOP, CFG_TOP, CFG_TOP, 1'b0);
        steady_run = 1'b1;
        repeat (TOP_TICKS) send(MD_TICK, cfg_shadow.press_level);
        steady_run = 1'b0;
        load_settings(16'd1, CFG_TOP, CFG_TOP, CFG_TOP, CFG_TOP, 1'b0);
        steady_run = 1'b1;
        send(MD_TICK, cfg_shadow.press_level);
        repeat (TOP_TICKS) send(MD_TICK, cfg_shadow.press_level);
        send(MD_TICK, ~cfg_shadow.press_level);
        send(MD_ACK, 1'b1);
        send(MD_TICK, ~cfg_shadow.press_level);
        steady_run = 1'b0;

        // random part, one register setting per phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            sl = rand_cfg(1, 8);
            lg = sl + rand_cfg(0, 8);
            kp = lg + rand_cfg(0, 8);
            case (p)
                0: load_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);  // bottom of range
                1: load_settings(rand_cfg(1, 6), rand_cfg(1, 14), sl, lg, kp, 1'b1);
                // thresholds in any order
                2: load_settings(rand_cfg(1, 4), rand_cfg(1, 12),
                                 rand_cfg(1, 10), rand_cfg(1, 10),
                                 rand_cfg(1, 10), rand_pin());
                // keep out of reach, release classes only
                3: load_settings(rand_cfg(1, 6), rand_cfg(1, 20), sl, lg, CFG_TOP,
                                 rand_pin());
                // first mark at or beyond every threshold
                4: load_settings(rand_cfg(1, 6), kp + rand_cfg(0, 3), sl, lg, kp,
                                 1'b0);
                default: load_settings(rand_cfg(1, 6), rand_cfg(1, 14), sl, lg, kp,
                                       rand_pin());
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    settle();                       // hold off until all results are back
                end else if (r < 20) begin
                    repeat ($urandom_range(1, 4))
                        send(t_mode'($urandom_range(0, 3)), rand_pin());
                end else begin
                    press_episode();
                end
            end
        end

        settle();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
